// ===== rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// assertion helpers for the contour edge crossing block, empty in synthesis
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// plain clocked property
`define CECI_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
// same-cycle implication
`define CECI_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
// next-cycle implication
`define CECI_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define CECI_ASSERT(label, clk, rst, prop, msg)
`define CECI_ASSERT_IMP(label, clk, rst, ante, cons, msg)
`define CECI_ASSERT_NEXT(label, clk, rst, ante, cons, msg)
`endif
`endif

// ===== rtl/ceci_pkg.sv =====
// ----------------------------------------------------------------------------
// ceci_pkg
// shared widths, types and helpers of the contour edge crossing pipeline
// ----------------------------------------------------------------------------
package ceci_pkg;

   localparam int unsigned WORD_W       = 32;            // q16.16 word
   localparam int unsigned SUM_W        = WORD_W + 1;    // sum of two distances
   localparam int unsigned PROD_W       = 2 * WORD_W;    // distance times span
   localparam int unsigned AXES         = 3;
   localparam int unsigned DIV_STEPS    = WORD_W;        // one quotient bit per stage
   localparam int unsigned FRONT_STAGES = 4;             // input, diff, select, multiply
   localparam int unsigned NUM_STAGES   = FRONT_STAGES + DIV_STEPS + 1;
   localparam int unsigned REQ_DATA_W   = 8 * WORD_W;
   localparam int unsigned RSP_DATA_W   = AXES * WORD_W;
   localparam int unsigned CSR_ADDR_W   = 3;
   localparam int unsigned CSR_DATA_W   = 32;

   // register index, taken from the word address bit
   localparam logic CSR_IDX_LEVEL = 1'b0;
   localparam logic CSR_IDX_SKIP  = 1'b1;

   typedef logic signed [WORD_W-1:0] word_type;
   typedef logic signed [WORD_W:0]   wide_type;
   typedef logic [WORD_W-1:0]        mag_type;
   typedef logic [SUM_W-1:0]         sum_type;
   typedef logic [PROD_W-1:0]        prod_type;

   typedef struct packed {
      word_type [AXES-1:0] a;
      word_type            a_level;
      word_type [AXES-1:0] b;
      word_type            b_level;
   } edge_type;

   typedef struct packed {
      logic                hit;
      sum_type             divisor;
      word_type [AXES-1:0] base;
      prod_type [AXES-1:0] prod;
   } prod_stage_type;

   typedef struct packed {
      logic                hit;
      word_type [AXES-1:0] base;
      mag_type  [AXES-1:0] quot;
   } quot_type;

   // magnitude of a widened difference of two words, always fits one word
   function automatic mag_type abs_mag(input wide_type x);
      wide_type t;
      t = x[WORD_W] ? -x : x;
      return t[WORD_W-1:0];
   endfunction

   // sign-extend one word by a bit
   function automatic wide_type widen(input word_type x);
      return $signed({x[WORD_W-1], x});
   endfunction

endpackage

// ===== rtl/ceci_front.sv =====
// ----------------------------------------------------------------------------
// ceci_front
// classification, distances, axis selection and products (three stages)
// ----------------------------------------------------------------------------
module ceci_front (
   input  logic                      clock,
   input  logic [2:0]                en,
   input  ceci_pkg::word_type        level,
   input  logic                      skip_flat,
   input  ceci_pkg::edge_type        edge_in,
   output ceci_pkg::prod_stage_type  prod_out
);
   import ceci_pkg::*;

   // stage 1: compares and raw differences
   logic     flat_ff, flat_in;
   logic     cross_ff, cross_in;
   wide_type dla_ff, dla_in;
   wide_type dlb_ff, dlb_in;
   wide_type dd_ff [AXES];
   wide_type dd_in [AXES];
   logic     lt_ff [AXES];
   logic     lt_in [AXES];
   word_type a1_ff [AXES];
   word_type b1_ff [AXES];

   // stage 2: magnitudes and choice of base
   logic     hit2_ff, hit2_in;
   sum_type  div2_ff, div2_in;
   word_type base2_ff [AXES];
   word_type base2_in [AXES];
   mag_type  fac2_ff [AXES];
   mag_type  fac2_in [AXES];
   mag_type  span2_ff [AXES];
   mag_type  span2_in [AXES];

   // stage 3: products
   prod_stage_type prod_ff, prod_in;

   mag_type d0, d1;

   always_comb begin
      flat_in  = !skip_flat && (edge_in.a_level == level) && (edge_in.b_level == level);
      cross_in = ((edge_in.a_level <= level) && (edge_in.b_level > level)) ||
                 ((edge_in.a_level >= level) && (edge_in.b_level < level));
      dla_in   = widen(level) - widen(edge_in.a_level);
      dlb_in   = widen(level) - widen(edge_in.b_level);
      for (int i = 0; i < AXES; i++) begin
         dd_in[i] = widen($signed(edge_in.b[i])) - widen($signed(edge_in.a[i]));
         lt_in[i] = $signed(edge_in.a[i]) < $signed(edge_in.b[i]);
      end
   end

   always_ff @(posedge clock) begin
      if (en[0]) begin
         flat_ff  <= flat_in;
         cross_ff <= cross_in;
         dla_ff   <= dla_in;
         dlb_ff   <= dlb_in;
         for (int i = 0; i < AXES; i++) begin
            dd_ff[i] <= dd_in[i];
            lt_ff[i] <= lt_in[i];
            a1_ff[i] <= $signed(edge_in.a[i]);
            b1_ff[i] <= $signed(edge_in.b[i]);
         end
      end
   end

   // flat edge: zero factor and unit divisor give a zero offset from a
   always_comb begin
      d0      = abs_mag(dla_ff);
      d1      = abs_mag(dlb_ff);
      hit2_in = flat_ff | cross_ff;
      div2_in = flat_ff ? SUM_W'(1) : (SUM_W'(d0) + SUM_W'(d1));
      for (int i = 0; i < AXES; i++) begin
         span2_in[i] = abs_mag(dd_ff[i]);
         if (flat_ff) begin
            base2_in[i] = a1_ff[i];
            fac2_in[i]  = '0;
         end else if (lt_ff[i]) begin
            base2_in[i] = a1_ff[i];
            fac2_in[i]  = d0;
         end else begin
            base2_in[i] = b1_ff[i];
            fac2_in[i]  = d1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en[1]) begin
         hit2_ff <= hit2_in;
         div2_ff <= div2_in;
         for (int i = 0; i < AXES; i++) begin
            base2_ff[i] <= base2_in[i];
            fac2_ff[i]  <= fac2_in[i];
            span2_ff[i] <= span2_in[i];
         end
      end
   end

   always_comb begin
      prod_in.hit     = hit2_ff;
      prod_in.divisor = div2_ff;
      for (int i = 0; i < AXES; i++) begin
         prod_in.base[i] = base2_ff[i];
         prod_in.prod[i] = PROD_W'(fac2_ff[i]) * PROD_W'(span2_ff[i]);
      end
   end

   always_ff @(posedge clock) begin
      if (en[2]) begin
         prod_ff <= prod_in;
      end
   end

   assign prod_out = prod_ff;

endmodule

// ===== rtl/ceci_div.sv =====
// ----------------------------------------------------------------------------
// ceci_div
// pipelined restoring divider, one quotient bit per stage on every axis
// ----------------------------------------------------------------------------
module ceci_div (
   input  logic                           clock,
   input  logic [ceci_pkg::DIV_STEPS-1:0] en,
   input  ceci_pkg::prod_stage_type       prod_in,
   output ceci_pkg::quot_type             quot_out
);
   import ceci_pkg::*;

   // remainder stays below the divisor; w shifts dividend bits out, quotient in
   sum_type  rem_ff  [DIV_STEPS][AXES];
   mag_type  w_ff    [DIV_STEPS][AXES];
   word_type base_ff [DIV_STEPS][AXES];
   sum_type  div_ff  [DIV_STEPS];
   logic     hit_ff  [DIV_STEPS];

   for (genvar j = 0; j < DIV_STEPS; j++) begin : g_step
      sum_type  rem_src [AXES];
      mag_type  w_src   [AXES];
      word_type base_src [AXES];
      sum_type  div_src;
      logic     hit_src;
      sum_type  rem_in  [AXES];
      mag_type  w_in    [AXES];

      if (j == 0) begin : g_first
         always_comb begin
            div_src = prod_in.divisor;
            hit_src = prod_in.hit;
            for (int i = 0; i < AXES; i++) begin
               rem_src[i]  = SUM_W'(prod_in.prod[i][PROD_W-1:WORD_W]);
               w_src[i]    = prod_in.prod[i][WORD_W-1:0];
               base_src[i] = $signed(prod_in.base[i]);
            end
         end
      end else begin : g_rest
         always_comb begin
            div_src = div_ff[j-1];
            hit_src = hit_ff[j-1];
            for (int i = 0; i < AXES; i++) begin
               rem_src[i]  = rem_ff[j-1][i];
               w_src[i]    = w_ff[j-1][i];
               base_src[i] = base_ff[j-1][i];
            end
         end
      end

      always_comb begin
         logic [SUM_W:0] trial;
         logic           ge;
         for (int i = 0; i < AXES; i++) begin
            trial     = {rem_src[i], w_src[i][WORD_W-1]};
            ge        = trial >= {1'b0, div_src};
            rem_in[i] = ge ? SUM_W'(trial - {1'b0, div_src}) : SUM_W'(trial);
            w_in[i]   = {w_src[i][WORD_W-2:0], ge};
         end
      end

      always_ff @(posedge clock) begin
         if (en[j]) begin
            div_ff[j] <= div_src;
            hit_ff[j] <= hit_src;
            for (int i = 0; i < AXES; i++) begin
               rem_ff[j][i]  <= rem_in[i];
               w_ff[j][i]    <= w_in[i];
               base_ff[j][i] <= base_src[i];
            end
         end
      end
   end

   always_comb begin
      quot_out.hit = hit_ff[DIV_STEPS-1];
      for (int i = 0; i < AXES; i++) begin
         quot_out.base[i] = base_ff[DIV_STEPS-1][i];
         quot_out.quot[i] = w_ff[DIV_STEPS-1][i];
      end
   end

endmodule

// ===== rtl/contour_edge_crossing.sv =====
// throughput: one edge per cycle unless a stalled result side backs up a full pipe;
//   the depth comes from the 32-stage divider, one quotient bit per stage,
//   after input, compare, select and multiply stages
// reset: synchronous, clears every pipeline valid bit and both csr registers
//   (level 0, flat check enabled); no clearing pass, ready right after reset
// ----------------------------------------------------------------------------
// contour_edge_crossing
// finds where the contour level crosses one mesh edge, streaming pipeline
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module contour_edge_crossing (
   input  logic                              clock,
   input  logic                              reset,
   // request channel
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // a_x, a_y, a_z, a_level, b_x, b_y, b_z, b_level, 32 bits each, low to high
   input  logic [ceci_pkg::REQ_DATA_W-1:0]   req_tdata,
   // result channel
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // out_x, out_y, out_z, 32 bits each, low to high
   output logic [ceci_pkg::RSP_DATA_W-1:0]   rsp_tdata,
   // hit
   output logic                              rsp_tuser,
   // csr port
   input  logic                              csr_psel,
   input  logic                              csr_penable,
   input  logic                              csr_pwrite,
   input  logic [ceci_pkg::CSR_ADDR_W-1:0]   csr_paddr,
   input  logic [ceci_pkg::CSR_DATA_W-1:0]   csr_pwdata,
   output logic [ceci_pkg::CSR_DATA_W-1:0]   csr_prdata,
   output logic                              csr_pready
);
   import ceci_pkg::*;

   // ------------------------------------------------------------------
   // csr registers: level at word 0, flat-check skip at word 1
   // ------------------------------------------------------------------
   word_type level_ff;
   logic     skip_ff;
   logic     csr_wr;
   logic     csr_idx;

   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel & csr_penable & csr_pwrite & csr_pready;
   assign csr_idx    = csr_paddr[2];

   always_ff @(posedge clock) begin
      if (reset) begin
         level_ff <= '0;
         skip_ff  <= 1'b0;
      end else if (csr_wr) begin
         unique case (csr_idx)
            CSR_IDX_LEVEL: level_ff <= $signed(csr_pwdata[WORD_W-1:0]);
            CSR_IDX_SKIP:  skip_ff  <= csr_pwdata[0];
            default:       ;
         endcase
      end
   end

   always_comb begin
      unique case (csr_idx)
         CSR_IDX_LEVEL: csr_prdata = CSR_DATA_W'(level_ff);
         CSR_IDX_SKIP:  csr_prdata = CSR_DATA_W'(skip_ff);
         default:       csr_prdata = '0;
      endcase
   end

   // ------------------------------------------------------------------
   // pipeline flow control
   // stage 0 input, 1..3 front, 4..35 divider, 36 output register
   // a stage loads when it is empty or everything after it can move,
   // so bubbles collapse and a stalled output only blocks a full pipe
   // ------------------------------------------------------------------
   logic [NUM_STAGES-1:0] valid_ff;
   logic [NUM_STAGES-1:0] en;

   for (genvar k = 0; k < NUM_STAGES; k++) begin : g_en
      assign en[k] = rsp_tready | ~(&valid_ff[NUM_STAGES-1:k]);
   end

   assign req_tready = en[0] & ~reset;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         if (en[0]) begin
            valid_ff[0] <= req_tvalid;
         end
         for (int k = 1; k < NUM_STAGES; k++) begin
            if (en[k]) begin
               valid_ff[k] <= valid_ff[k-1];
            end
         end
      end
   end

   // ------------------------------------------------------------------
   // stage 0: request beat register
   // ------------------------------------------------------------------
   edge_type edge_ff, edge_in;

   always_comb begin
      for (int i = 0; i < AXES; i++) begin
         edge_in.a[i] = $signed(req_tdata[i*WORD_W +: WORD_W]);
         edge_in.b[i] = $signed(req_tdata[(AXES+1+i)*WORD_W +: WORD_W]);
      end
      edge_in.a_level = $signed(req_tdata[AXES*WORD_W +: WORD_W]);
      edge_in.b_level = $signed(req_tdata[(2*AXES+1)*WORD_W +: WORD_W]);
   end

   always_ff @(posedge clock) begin
      if (en[0]) begin
         edge_ff <= edge_in;
      end
   end

   // ------------------------------------------------------------------
   // stages 1..3: classify, distances, products
   // ------------------------------------------------------------------
   prod_stage_type prod_q;

   ceci_front u_front (
      .clock     (clock),
      .en        (en[FRONT_STAGES-1:1]),
      .level     (level_ff),
      .skip_flat (skip_ff),
      .edge_in   (edge_ff),
      .prod_out  (prod_q)
   );

   // ------------------------------------------------------------------
   // stages 4..35: offset = product / distance sum
   // ------------------------------------------------------------------
   quot_type quot_q;

   ceci_div u_div (
      .clock    (clock),
      .en       (en[FRONT_STAGES+DIV_STEPS-1:FRONT_STAGES]),
      .prod_in  (prod_q),
      .quot_out (quot_q)
   );

   // ------------------------------------------------------------------
   // stage 36: base plus offset, zero when there is no hit
   // ------------------------------------------------------------------
   logic                   hit_ff;
   logic [RSP_DATA_W-1:0]  pos_ff, pos_in;

   always_comb begin
      for (int i = 0; i < AXES; i++) begin
         pos_in[i*WORD_W +: WORD_W] = quot_q.hit ?
            WORD_W'(quot_q.base[i] + $signed(quot_q.quot[i])) : '0;
      end
   end

   always_ff @(posedge clock) begin
      if (en[NUM_STAGES-1]) begin
         hit_ff <= quot_q.hit;
         pos_ff <= pos_in;
      end
   end

   assign rsp_tvalid = valid_ff[NUM_STAGES-1];
   assign rsp_tdata  = pos_ff;
   assign rsp_tuser  = hit_ff;

   // ------------------------------------------------------------------
   // checks
   // ------------------------------------------------------------------
   `CECI_ASSERT_IMP(a_nohit_zero, clock, reset, rsp_tvalid && !rsp_tuser, rsp_tdata == '0, "miss beat carries a nonzero point")
   `CECI_ASSERT_IMP(a_stall_full, clock, reset, !req_tready, &valid_ff, "request stalled while the pipeline has a bubble")
   `CECI_ASSERT_IMP(a_out_source, clock, reset, $rose(rsp_tvalid), $past(valid_ff[NUM_STAGES-2]), "result beat appeared without a divider item")
   `CECI_ASSERT_NEXT(a_accept_fill, clock, reset, req_tvalid && req_tready, valid_ff[0], "accepted beat not captured in the input stage")

endmodule

// ===== test/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// streams mesh edges through the contour edge crossing block under random
// source gaps and sink stalls, predicts every crossing beat in a scoreboard
// and compares hit and the three coordinates beat by beat, across several
// level and flat-check settings written over the csr port
// ----------------------------------------------------------------------------
module tb;
   import ceci_pkg::*;

   // request beat, first field in the lowest bits
   typedef struct packed {
      word_type b_level;
      word_type b_z;
      word_type b_y;
      word_type b_x;
      word_type a_level;
      word_type a_z;
      word_type a_y;
      word_type a_x;
   } mesh_edge_t;

   typedef struct packed {
      logic     hit;
      word_type x;
      word_type y;
      word_type z;
   } crossing_t;

   localparam word_type W_MIN = 32'sh8000_0000;
   localparam word_type W_MAX = 32'sh7fff_ffff;
   localparam word_type W_ONE = 32'sh0001_0000;   // 1.0 in q16.16

   // byte addresses, one 32-bit register every 4 bytes
   localparam logic [CSR_ADDR_W-1:0] LEVEL_ADDR = {CSR_IDX_LEVEL, 2'b00};
   localparam logic [CSR_ADDR_W-1:0] SKIP_ADDR  = {CSR_IDX_SKIP, 2'b00};

   localparam int unsigned ITEMS_PER_PHASE = 225;
   localparam int unsigned RANDOM_PHASES   = 8;
   localparam int unsigned TAIL_CYCLES     = 48;   // pipeline is 37 deep

   // ------------------------------------------------------------------------
   // scoreboard: own copy of the csr settings, queue of crossings due
   // ------------------------------------------------------------------------
   class crossing_tracker;
      word_type    level;
      bit          skip_flat;
      crossing_t   crossings_due[$];
      int unsigned mismatches;

      function new();
         level      = '0;
         skip_flat  = 1'b0;
         mismatches = 0;
      endfunction

      // walk from the lower coordinate by span times the distance ratio
      function word_type lerp_axis(word_type a, word_type b, logic [63:0] d0,
                                   logic [63:0] d1, logic [63:0] sum);
         longint      sa;
         longint      sb;
         logic [63:0] span;
         logic [63:0] off;
         longint      res;
         sa   = a;
         sb   = b;
         span = (sa >= sb) ? sa - sb : sb - sa;
         if (sa < sb) begin
            off = (sum == 0) ? 64'd0 : (d0 * span) / sum;
            res = sa + longint'(off);
         end else begin
            off = (sum == 0) ? 64'd0 : (d1 * span) / sum;
            res = sb + longint'(off);
         end
         return word_type'(res);
      endfunction

      function crossing_t crossing_of(mesh_edge_t e);
         longint      lv;
         longint      al;
         longint      bl;
         logic [63:0] d0;
         logic [63:0] d1;
         logic [63:0] sum;
         crossing_t   r;
         lv = level;
         al = e.a_level;
         bl = e.b_level;
         r  = '0;
         if (!skip_flat && al == lv && bl == lv) begin
            // edge lies on the level, report endpoint a
            r.hit = 1'b1;
            r.x   = e.a_x;
            r.y   = e.a_y;
            r.z   = e.a_z;
         end else if ((al <= lv && bl > lv) || (al >= lv && bl < lv)) begin
            d0    = (lv >= al) ? lv - al : al - lv;
            d1    = (lv >= bl) ? lv - bl : bl - lv;
            sum   = d0 + d1;
            r.hit = 1'b1;
            r.x   = lerp_axis(e.a_x, e.b_x, d0, d1, sum);
            r.y   = lerp_axis(e.a_y, e.b_y, d0, d1, sum);
            r.z   = lerp_axis(e.a_z, e.b_z, d0, d1, sum);
         end
         return r;
      endfunction

      function void note_edge(mesh_edge_t e);
         crossings_due.push_back(crossing_of(e));
      endfunction

      function int outstanding();
         return crossings_due.size();
      endfunction

      function void check_field(string name, logic [31:0] want, logic [31:0] got);
         if (got !== want) begin
            $error("%s: expected %0d, got %0d", name, $signed(want), $signed(got));
            mismatches++;
         end
      endfunction

      function void check_crossing(crossing_t got);
         crossing_t want;
         if (crossings_due.size() == 0) begin
            $error("result beat with no edge pending: hit %b x %0d y %0d z %0d",
                   got.hit, got.x, got.y, got.z);
            mismatches++;
            return;
         end
         want = crossings_due.pop_front();
         check_field("hit", {31'd0, want.hit}, {31'd0, got.hit});
         check_field("out_x", want.x, got.x);
         check_field("out_y", want.y, got.y);
         check_field("out_z", want.z, got.z);
      endfunction
   endclass

   // ------------------------------------------------------------------------
   // clock, dut signals
   // ------------------------------------------------------------------------
   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  rsp_tuser;
   logic                  csr_psel = 1'b0;
   logic                  csr_penable = 1'b0;
   logic                  csr_pwrite = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_paddr = '0;
   logic [CSR_DATA_W-1:0] csr_pwdata = '0;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   crossing_tracker sb = new();

   // when set, neither side idles, so the pipeline runs at full rate
   bit burst_mode = 1'b0;

   always #1 clock = ~clock;

   contour_edge_crossing uut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   // ------------------------------------------------------------------------
   // csr access, called right after a rising edge; psel is left high so
   // back-to-back accesses go straight into the next setup cycle
   // ------------------------------------------------------------------------
   task automatic csr_write(input logic [CSR_ADDR_W-1:0] addr,
                            input logic [CSR_DATA_W-1:0] data);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= addr;
      csr_pwdata  <= data;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
   endtask

   task automatic csr_read(input logic [CSR_ADDR_W-1:0] addr,
                           output logic [CSR_DATA_W-1:0] data);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      csr_paddr   <= addr;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      // prdata as seen during the access cycle
      data = csr_prdata;
   endtask

   // write both registers, mirror them in the scoreboard and read them back
   task automatic apply_settings(input word_type lvl, input bit skip);
      logic [CSR_DATA_W-1:0] rd;
      logic [CSR_DATA_W-1:0] skip_word;
      // only bit 0 of the flat-check register counts, upper bits are noise
      skip_word = {$urandom} & ~32'd1;
      skip_word[0] = skip;
      csr_write(LEVEL_ADDR, lvl);
      csr_write(SKIP_ADDR, skip_word);
      sb.level     = lvl;
      sb.skip_flat = skip;
      csr_read(LEVEL_ADDR, rd);
      if (rd !== lvl) begin
         $error("contour_level: expected %0d, got %0d", lvl, $signed(rd));
         sb.mismatches++;
      end
      csr_read(SKIP_ADDR, rd);
      if (rd[0] !== skip) begin
         $error("skip_flat_check: expected %0d, got %0d", skip, rd[0]);
         sb.mismatches++;
      end
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
   endtask

   // ------------------------------------------------------------------------
   // request side: random gap, then hold the beat until it is taken
   // ------------------------------------------------------------------------
   task automatic send_edge(input mesh_edge_t e);
      int unsigned gap;
      gap = burst_mode ? 0 : $urandom_range(0, 7);
      if (gap != 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= e;
      do @(posedge clock); while (!req_tready);
      sb.note_edge(e);
   endtask

   // wait for every predicted crossing to come back
   task automatic drain();
      while (sb.outstanding() != 0) @(posedge clock);
   endtask

   // ------------------------------------------------------------------------
   // stimulus helpers
   // ------------------------------------------------------------------------
   function automatic mesh_edge_t make_edge(word_type ax, word_type ay, word_type az,
                                            word_type al, word_type bx, word_type by,
                                            word_type bz, word_type bl);
      mesh_edge_t e;
      e.a_x = ax;  e.a_y = ay;  e.a_z = az;  e.a_level = al;
      e.b_x = bx;  e.b_y = by;  e.b_z = bz;  e.b_level = bl;
      return e;
   endfunction

   // scalar strictly below lvl, or lvl itself when nothing lies below
   function automatic word_type level_under(word_type lvl);
      longint lo;
      longint hi;
      longint span;
      longint off;
      lo = -64'sd2147483648;
      hi = longint'(lvl) - 1;
      if (hi < lo) return lvl;
      span = hi - lo;
      case ($urandom_range(0, 3))
         0: begin
            // just under the level
            off = $urandom_range(0, 255);
            if (off > span) off = span;
            return word_type'(hi - off);
         end
         1: return word_type'(lo);
         default: return word_type'(lo + longint'($urandom) % (span + 1));
      endcase
   endfunction

   // scalar strictly above lvl, or lvl itself when nothing lies above
   function automatic word_type level_over(word_type lvl);
      longint lo;
      longint hi;
      longint span;
      longint off;
      lo = longint'(lvl) + 1;
      hi = 64'sd2147483647;
      if (lo > hi) return lvl;
      span = hi - lo;
      case ($urandom_range(0, 3))
         0: begin
            off = $urandom_range(0, 255);
            if (off > span) off = span;
            return word_type'(lo + off);
         end
         1: return word_type'(hi);
         default: return word_type'(lo + longint'($urandom) % (span + 1));
      endcase
   endfunction

   function automatic word_type random_coord();
      case ($urandom_range(0, 7))
         0: return W_MIN;
         1: return W_MAX;
         2: return $urandom_range(0, 1) ? word_type'(0) : word_type'(-1);
         default: return word_type'($urandom);
      endcase
   endfunction

   // second endpoint: same coordinate, a close one, or unrelated
   function automatic word_type partner_coord(word_type a);
      case ($urandom_range(0, 7))
         0: return a;
         1: return word_type'(a + $urandom_range(0, 1023) - 512);
         default: return random_coord();
      endcase
   endfunction

   // mostly edges that straddle or touch the level, some noise
   function automatic mesh_edge_t random_edge(word_type lvl);
      mesh_edge_t  e;
      int unsigned pick;
      e.a_x = random_coord();
      e.a_y = random_coord();
      e.a_z = random_coord();
      e.b_x = partner_coord(e.a_x);
      e.b_y = partner_coord(e.a_y);
      e.b_z = partner_coord(e.a_z);
      pick  = $urandom_range(0, 15);
      if (pick < 10) begin
         // straddling edge, sometimes starting exactly on the level
         if ($urandom_range(0, 1)) begin
            e.a_level = ($urandom_range(0, 5) == 0) ? lvl : level_under(lvl);
            e.b_level = level_over(lvl);
         end else begin
            e.a_level = ($urandom_range(0, 5) == 0) ? lvl : level_over(lvl);
            e.b_level = level_under(lvl);
         end
      end else if (pick < 12) begin
         // flat edge on the level
         e.a_level = lvl;
         e.b_level = lvl;
      end else if (pick < 14) begin
         // both on one side, or ending on the level: no crossing
         case ($urandom_range(0, 3))
            0: begin e.a_level = level_under(lvl); e.b_level = level_under(lvl); end
            1: begin e.a_level = level_over(lvl);  e.b_level = level_over(lvl);  end
            2: begin e.a_level = level_under(lvl); e.b_level = lvl;              end
            default: begin e.a_level = level_over(lvl); e.b_level = lvl;         end
         endcase
      end else begin
         e.a_level = word_type'($urandom);
         e.b_level = word_type'($urandom);
      end
      return e;
   endfunction

   // ------------------------------------------------------------------------
   // result side: random stall before each beat, check it on acceptance
   // ------------------------------------------------------------------------
   initial begin
      crossing_t   got;
      int unsigned stall;
      while (reset) @(posedge clock);
      forever begin
         stall = burst_mode ? 0 : $urandom_range(0, 7);
         if (stall != 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!rsp_tvalid);
         got.hit = rsp_tuser;
         got.x   = rsp_tdata[31:0];
         got.y   = rsp_tdata[63:32];
         got.z   = rsp_tdata[95:64];
         sb.check_crossing(got);
      end
   end

   // ------------------------------------------------------------------------
   // main sequence
   // ------------------------------------------------------------------------
   initial begin
      word_type    lvl;
      bit          skip;
      int unsigned p;
      int unsigned n;

      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed edges around level 0 with the flat check on
      apply_settings('0, 1'b0);
      // flat edge, hit at a
      send_edge(make_edge(32'sd12345, -32'sd7, W_MAX, '0, W_MIN, 32'sd99, 32'sd0, '0));
      // straddle upward and downward
      send_edge(make_edge('0, '0, '0, -W_ONE, W_ONE, W_ONE, W_ONE, W_ONE));
      send_edge(make_edge('0, '0, '0, W_ONE, W_ONE, -W_ONE, 32'sd3, -32'sd3));
      // start on the level, end above or below
      send_edge(make_edge(32'sd100, 32'sd500, -32'sd100, '0, 32'sd300, 32'sd200,
                          32'sd50, 32'sd17));
      send_edge(make_edge(32'sd100, 32'sd500, -32'sd100, '0, 32'sd300, 32'sd200,
                          32'sd50, -32'sd17));
      // end on the level: no crossing
      send_edge(make_edge(W_ONE, W_ONE, W_ONE, -32'sd1, '0, '0, '0, '0));
      send_edge(make_edge(W_ONE, W_ONE, W_ONE, 32'sd1, '0, '0, '0, '0));
      // both above, both below
      send_edge(make_edge(32'sd5, 32'sd6, 32'sd7, 32'sd1, 32'sd8, 32'sd9, 32'sd10, W_MAX));
      send_edge(make_edge(32'sd5, 32'sd6, 32'sd7, W_MIN, 32'sd8, 32'sd9, 32'sd10, -32'sd1));
      // widest spans and distance sums
      send_edge(make_edge(W_MIN, W_MIN, W_MIN, W_MIN, W_MAX, W_MAX, W_MAX, W_MAX));
      send_edge(make_edge(W_MAX, W_MAX, W_MAX, W_MAX, W_MIN, W_MIN, W_MIN, W_MIN));
      // axes running in opposite directions
      send_edge(make_edge(W_MIN, W_MAX, '0, W_MIN, W_MAX, W_MIN, -32'sd1, 32'sd1));
      // zero span on every axis
      send_edge(make_edge(32'sd123, -32'sd5, W_MAX, -32'sd3, 32'sd123, -32'sd5, W_MAX,
                          32'sd7));
      // all-ones and zero coordinates
      send_edge(make_edge(-32'sd1, -32'sd1, -32'sd1, -32'sd2, '0, '0, '0, 32'sd5));
      // on the level to the far top, and the far bottom to the level
      send_edge(make_edge(W_MAX, W_MIN, 32'sd42, '0, W_MIN, W_MAX, -32'sd42, W_MAX));
      send_edge(make_edge(W_MAX, W_MIN, 32'sd42, W_MIN, W_MIN, W_MAX, -32'sd42, '0));
      send_edge(make_edge(32'sh5555_5555, 32'shAAAA_AAAA, 32'sh0F0F_0F0F, 32'sh1234_5678,
                          32'shAAAA_AAAA, 32'sh5555_5555, 32'shF0F0_F0F0,
                          32'shEDCB_A988));
      req_tvalid <= 1'b0;
      drain();

      // flat check off at the bottom level: a flat edge is no hit, crossings
      // can only start on the level
      apply_settings(W_MIN, 1'b1);
      send_edge(make_edge(32'sd1, 32'sd2, 32'sd3, W_MIN, 32'sd4, 32'sd5, 32'sd6, W_MIN));
      send_edge(make_edge(W_MIN, '0, W_MAX, W_MIN, W_MAX, '0, W_MIN, W_MAX));
      send_edge(make_edge(32'sd10, 32'sd20, 32'sd30, W_MIN, -32'sd10, 32'sd40, 32'sd30,
                          32'sd5));
      req_tvalid <= 1'b0;
      drain();

      // random phases, each under its own level and flat-check setting
      for (p = 0; p < RANDOM_PHASES; p++) begin
         case (p)
            0: begin lvl = W_MAX;                               skip = 1'b0; end
            1: begin lvl = W_MIN;                               skip = 1'b1; end
            2: begin lvl = '0;                                  skip = 1'b1; end
            3: begin lvl = word_type'($urandom);                skip = 1'b0; end
            4: begin lvl = word_type'($urandom_range(0, 1 << 21) - (1 << 20));
                     skip = 1'b1; end
            5: begin lvl = word_type'($urandom);                skip = 1'b0; end
            6: begin lvl = W_MIN;                               skip = 1'b0; end
            default: begin lvl = W_MAX;                         skip = 1'b1; end
         endcase
         apply_settings(lvl, skip);
         for (n = 0; n < ITEMS_PER_PHASE; n++) begin
            // switch between idling and full-rate stretches now and then
            if (n % 45 == 0) burst_mode = ($urandom_range(0, 3) == 0);
            send_edge(random_edge(lvl));
         end
         req_tvalid <= 1'b0;
         drain();
      end

      // let anything stray come out of the pipeline
      repeat (TAIL_CYCLES) @(posedge clock);
      if (sb.mismatches == 0 && sb.outstanding() == 0) begin
         $display("tb: done, clean");
      end else begin
         $display("tb: done, errors");
      end
      $finish;
   end

   // hang guard, far above the slowest correct run
   initial begin
      #400000;
      $display("tb: done, errors");
      $finish;
   end

endmodule
